// File: rtl/core/lsp_pkg.sv
`default_nettype none
package lsp_pkg;

  localparam int DATA_W = 32;
  localparam int WINDOW_DEPTH_DEF = 256;

  localparam logic CMD_ADD    = 1'b0;
  localparam logic CMD_REPORT = 1'b1;

  // floor(x/100) for x below 2^20: reciprocal 2^26/100 rounded up
  localparam logic [19:0] RECIP_100 = 20'd671089;
  localparam int RECIP_SHIFT = 26;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RANK,
    ST_SEL,
    ST_WAIT,
    ST_OUT
  } lsp_state_t;

  typedef enum logic [2:0] {
    SP_IDLE,
    SP_DIVM,
    SP_MULA,
    SP_MULB,
    SP_SQRT,
    SP_DIVJ,
    SP_DONE
  } stats_phase_t;

  typedef struct packed {
    logic add;
    logic rank_load;
    logic rank_step;
    logic sel_step;
  } cell_ctrl_t;

  function automatic logic [19:0] div100(input logic [19:0] x);
    logic [39:0] p;
    p = 40'(x) * 40'(RECIP_100);
    return 20'(p[39:RECIP_SHIFT]);
  endfunction

  function automatic logic [DATA_W-1:0] sat32(input logic [63:0] v);
    return (v[63:DATA_W] != '0) ? '1 : v[DATA_W-1:0];
  endfunction

endpackage
`default_nettype wire

// File: rtl/core/lsp_cell.sv
`default_nettype none
module lsp_cell import lsp_pkg::*; #(
  parameter int IW  = 8,
  parameter int IDX = 0
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire cell_ctrl_t        ctrl,
  input  wire logic [DATA_W-1:0] prev_val,
  input  wire logic              prev_vld,
  input  wire logic [IW-1:0]     prev_rank,
  input  wire logic [DATA_W-1:0] prev_pval,
  input  wire logic [IW-1:0]     prev_ptag,
  input  wire logic              prev_pvld,
  output logic      [DATA_W-1:0] val,
  output logic                   vld,
  output logic      [IW-1:0]     rank,
  output logic      [DATA_W-1:0] pval,
  output logic      [IW-1:0]     ptag,
  output logic                   pvld
);

  logic [DATA_W-1:0] val_r, pval_r;
  logic              vld_r, pvld_r;
  logic [IW-1:0]     rank_r, ptag_r;
  logic              hit;

  // probe ranks below this cell's value; equal values broken by cell index
  assign hit = pvld_r && vld_r &&
               ((pval_r < val_r) || ((pval_r == val_r) && (ptag_r < IW'(IDX))));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= 1'b0;
      pvld_r <= 1'b0;
    end else begin
      if (ctrl.add || ctrl.sel_step) begin
        val_r <= prev_val;
        vld_r <= prev_vld;
      end
      if (ctrl.sel_step) rank_r <= prev_rank;
      if (ctrl.rank_load) begin
        pval_r <= val_r;
        ptag_r <= IW'(IDX);
        pvld_r <= vld_r;
        rank_r <= '0;
      end else if (ctrl.rank_step) begin
        rank_r <= rank_r + IW'(hit);
        pval_r <= prev_pval;
        ptag_r <= prev_ptag;
        pvld_r <= prev_pvld;
      end
    end
  end

  assign val  = val_r;
  assign vld  = vld_r;
  assign rank = rank_r;
  assign pval = pval_r;
  assign ptag = ptag_r;
  assign pvld = pvld_r;

endmodule
`default_nettype wire

// File: rtl/core/lsp_stats.sv
`default_nettype none
module lsp_stats import lsp_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [63:0]       sum,
  input  wire logic [63:0]       sqsum,
  input  wire logic [DATA_W-1:0] n,
  output logic                   done,
  output logic      [DATA_W-1:0] mean,
  output logic      [DATA_W-1:0] jitter
);

  stats_phase_t phase_r, phase_nxt;
  logic [5:0]   cnt_r, cnt_nxt;
  logic [63:0]  num_r, num_nxt;
  logic [32:0]  rem_r, rem_nxt;
  logic [127:0] acc_r, acc_nxt, mcd_r, mcd_nxt, a_r, a_nxt, v_r, v_nxt;
  logic [63:0]  mpl_r, mpl_nxt, root_r, root_nxt;
  logic [66:0]  srem_r, srem_nxt;
  logic [DATA_W-1:0] mean_r, mean_nxt, jit_r, jit_nxt;

  logic [32:0]  rem_sh, rem_step;
  logic         dge;
  logic [63:0]  num_step;
  logic [127:0] acc_step;
  logic [66:0]  srem_sh, trial, srem_step;
  logic         sge;
  logic [63:0]  root_step;

  always_comb begin
    rem_sh   = {rem_r[31:0], num_r[63]};
    dge      = rem_sh >= {1'b0, n};
    rem_step = dge ? rem_sh - {1'b0, n} : rem_sh;
    num_step = {num_r[62:0], dge};

    acc_step = mpl_r[0] ? acc_r + mcd_r : acc_r;

    srem_sh   = {srem_r[64:0], v_r[127:126]};
    trial     = {1'b0, root_r, 2'b01};
    sge       = srem_sh >= trial;
    srem_step = sge ? srem_sh - trial : srem_sh;
    root_step = {root_r[62:0], sge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= SP_IDLE;
    end else begin
      phase_r <= phase_nxt;
    end
    cnt_r  <= cnt_nxt;
    num_r  <= num_nxt;
    rem_r  <= rem_nxt;
    acc_r  <= acc_nxt;
    mcd_r  <= mcd_nxt;
    mpl_r  <= mpl_nxt;
    a_r    <= a_nxt;
    v_r    <= v_nxt;
    root_r <= root_nxt;
    srem_r <= srem_nxt;
    mean_r <= mean_nxt;
    jit_r  <= jit_nxt;
  end

  always_comb begin
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r - 6'd1;
    num_nxt   = num_r;
    rem_nxt   = rem_r;
    acc_nxt   = acc_r;
    mcd_nxt   = mcd_r;
    mpl_nxt   = mpl_r;
    a_nxt     = a_r;
    v_nxt     = v_r;
    root_nxt  = root_r;
    srem_nxt  = srem_r;
    mean_nxt  = mean_r;
    jit_nxt   = jit_r;
    if (start) begin
      phase_nxt = SP_DIVM;
      cnt_nxt   = 6'd63;
      num_nxt   = sum;
      rem_nxt   = '0;
    end else begin
      case (phase_r)
        SP_DIVM: begin
          num_nxt = num_step;
          rem_nxt = rem_step;
          if (cnt_r == 6'd0) begin
            mean_nxt  = sat32(num_step);
            acc_nxt   = '0;
            mcd_nxt   = {64'd0, sqsum};
            mpl_nxt   = {32'd0, n};
            phase_nxt = SP_MULA;
          end
        end
        SP_MULA, SP_MULB: begin
          acc_nxt = acc_step;
          mcd_nxt = {mcd_r[126:0], 1'b0};
          mpl_nxt = {1'b0, mpl_r[63:1]};
          if (cnt_r == 6'd0) begin
            if (phase_r == SP_MULA) begin
              a_nxt     = acc_step;
              acc_nxt   = '0;
              mcd_nxt   = {64'd0, sum};
              mpl_nxt   = sum;
              phase_nxt = SP_MULB;
            end else begin
              // n*sumsq - sum^2, clamped at zero; jitter only from two samples on
              v_nxt     = ((n > 32'd1) && (a_r > acc_step)) ? a_r - acc_step : '0;
              root_nxt  = '0;
              srem_nxt  = '0;
              phase_nxt = SP_SQRT;
            end
          end
        end
        SP_SQRT: begin
          srem_nxt = srem_step;
          root_nxt = root_step;
          v_nxt    = {v_r[125:0], 2'b00};
          if (cnt_r == 6'd0) begin
            num_nxt   = root_step;
            rem_nxt   = '0;
            phase_nxt = SP_DIVJ;
          end
        end
        SP_DIVJ: begin
          num_nxt = num_step;
          rem_nxt = rem_step;
          if (cnt_r == 6'd0) begin
            jit_nxt   = sat32(num_step);
            phase_nxt = SP_DONE;
          end
        end
        default: begin
          cnt_nxt = cnt_r;
        end
      endcase
    end
  end

  assign done   = (phase_r == SP_DONE);
  assign mean   = mean_r;
  assign jitter = jit_r;

endmodule
`default_nettype wire

// File: rtl/core/latency_statistics_percentiles_unit.sv
// Add beats: one per cycle while idle, no result; window shifts one cell per add.
// Report beats: one result each; the rank and select passes walk the cell ring
//   twice, while the stats engine computes mean and jitter alongside them.
// Input is stalled from a report's acceptance until its result is taken.
// Reset (synchronous, rst_n low) clears sums, count, min/max and cell valid bits.
`default_nettype none
module latency_statistics_percentiles_unit import lsp_pkg::*; #(
  parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic              in_cmd,
  input  wire logic [DATA_W-1:0] in_latency_ns,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic                   out_has_samples,
  output logic      [DATA_W-1:0] out_sample_total,
  output logic      [DATA_W-1:0] out_min_ns,
  output logic      [DATA_W-1:0] out_max_ns,
  output logic      [DATA_W-1:0] out_mean_ns,
  output logic      [DATA_W-1:0] out_jitter_ns,
  output logic      [DATA_W-1:0] out_p50_ns,
  output logic      [DATA_W-1:0] out_p90_ns,
  output logic      [DATA_W-1:0] out_p99_ns
);

  localparam int FW = $clog2(WINDOW_DEPTH + 1);
  localparam int IW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int LAST = WINDOW_DEPTH - 1;

  lsp_state_t state_r, state_nxt;
  logic [FW-1:0] cnt_r, cnt_nxt;
  cell_ctrl_t ctrl;
  logic accept, add_beat, rep_beat, has;

  logic [63:0]       sum_r, sq_r;
  logic [63:0]       sq_prod;
  logic [DATA_W-1:0] min_r, max_r, count_r;
  logic [FW-1:0]     fill_r, t50_r, t90_r, t99_r;
  logic [DATA_W-1:0] p50_r, p90_r, p99_r;
  logic              stats_done;
  logic [DATA_W-1:0] mean, jitter;

  logic [DATA_W-1:0] c_val [WINDOW_DEPTH];
  logic              c_vld [WINDOW_DEPTH];
  logic [IW-1:0]     c_rank[WINDOW_DEPTH];
  logic [DATA_W-1:0] c_pval[WINDOW_DEPTH];
  logic [IW-1:0]     c_ptag[WINDOW_DEPTH];
  logic              c_pvld[WINDOW_DEPTH];

  logic [DATA_W-1:0] head_val;
  logic              head_vld;

  assign accept   = in_valid && !in_stall;
  assign add_beat = accept && (in_cmd == CMD_ADD);
  assign rep_beat = accept && (in_cmd == CMD_REPORT);
  assign sq_prod  = 64'(in_latency_ns) * 64'(in_latency_ns);

  // new sample enters cell 0 on add; the tail wraps around during select
  assign head_val = (state_r == ST_IDLE) ? in_latency_ns : c_val[LAST];
  assign head_vld = (state_r == ST_IDLE) ? 1'b1 : c_vld[LAST];

  for (genvar i = 0; i < WINDOW_DEPTH; i++) begin : g_cell
    localparam int PREV = (i == 0) ? LAST : i - 1;
    lsp_cell #(.IW(IW), .IDX(i)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctrl     (ctrl),
      .prev_val ((i == 0) ? head_val : c_val[PREV]),
      .prev_vld ((i == 0) ? head_vld : c_vld[PREV]),
      .prev_rank(c_rank[PREV]),
      .prev_pval(c_pval[PREV]),
      .prev_ptag(c_ptag[PREV]),
      .prev_pvld(c_pvld[PREV]),
      .val      (c_val[i]),
      .vld      (c_vld[i]),
      .rank     (c_rank[i]),
      .pval     (c_pval[i]),
      .ptag     (c_ptag[i]),
      .pvld     (c_pvld[i])
    );
  end

  lsp_stats u_stats (
    .clk   (clk),
    .rst_n (rst_n),
    .start (rep_beat),
    .sum   (sum_r),
    .sqsum (sq_r),
    .n     (count_r),
    .done  (stats_done),
    .mean  (mean),
    .jitter(jitter)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      sum_r   <= '0;
      sq_r    <= '0;
      min_r   <= '1;
      max_r   <= '0;
      count_r <= '0;
      fill_r  <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      if (add_beat) begin
        sum_r <= sum_r + 64'(in_latency_ns);
        sq_r  <= sq_r + sq_prod;
        if (in_latency_ns < min_r) min_r <= in_latency_ns;
        if (in_latency_ns > max_r) max_r <= in_latency_ns;
        if (count_r != '1) count_r <= count_r + 32'd1;
        if (fill_r != FW'(WINDOW_DEPTH)) fill_r <= fill_r + FW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rep_beat) begin
      t50_r <= fill_r >> 1;
      t90_r <= FW'(div100(20'(fill_r) * 20'd90));
      t99_r <= FW'(div100(20'(fill_r) * 20'd99));
    end
    if ((state_r == ST_SEL) && c_vld[LAST]) begin
      if (c_rank[LAST] == t50_r[IW-1:0]) p50_r <= c_val[LAST];
      if (c_rank[LAST] == t90_r[IW-1:0]) p90_r <= c_val[LAST];
      if (c_rank[LAST] == t99_r[IW-1:0]) p99_r <= c_val[LAST];
    end
  end

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    ctrl           = '0;
    ctrl.add       = add_beat;
    ctrl.rank_load = rep_beat;
    case (state_r)
      ST_IDLE: begin
        cnt_nxt = '0;
        if (rep_beat) state_nxt = ST_RANK;
      end
      ST_RANK: begin
        ctrl.rank_step = 1'b1;
        cnt_nxt = cnt_r + FW'(1);
        if (cnt_r == FW'(LAST)) begin
          cnt_nxt   = '0;
          state_nxt = ST_SEL;
        end
      end
      ST_SEL: begin
        ctrl.sel_step = 1'b1;
        cnt_nxt = cnt_r + FW'(1);
        if (cnt_r == FW'(LAST)) begin
          cnt_nxt   = '0;
          state_nxt = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (stats_done) state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (!out_stall) state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = (state_r == ST_OUT);
  assign has       = (count_r != '0);

  assign out_has_samples  = has;
  assign out_sample_total = count_r;
  assign out_min_ns       = has ? min_r  : '0;
  assign out_max_ns       = has ? max_r  : '0;
  assign out_mean_ns      = has ? mean   : '0;
  assign out_jitter_ns    = has ? jitter : '0;
  assign out_p50_ns       = has ? p50_r  : '0;
  assign out_p90_ns       = has ? p90_r  : '0;
  assign out_p99_ns       = has ? p99_r  : '0;

endmodule
`default_nettype wire

// File: rtl/core/lsp_checker.sv
`default_nettype none
module lsp_checker import lsp_pkg::*; (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_stall,
  input wire logic              out_valid,
  input wire logic              out_stall,
  input wire logic              out_has_samples,
  input wire logic [DATA_W-1:0] out_sample_total,
  input wire logic [DATA_W-1:0] out_min_ns,
  input wire logic [DATA_W-1:0] out_max_ns,
  input wire logic [DATA_W-1:0] out_p50_ns,
  input wire logic [DATA_W-1:0] out_p90_ns,
  input wire logic [DATA_W-1:0] out_p99_ns
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result beat dropped while stalled");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input open while a report is pending");

  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_has_samples |->
      out_sample_total == '0 && out_min_ns == '0 && out_max_ns == '0 &&
      out_p50_ns == '0 && out_p99_ns == '0)
    else $error("empty report carries nonzero fields");

  a_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_has_samples |->
      out_min_ns <= out_max_ns && out_p50_ns <= out_p90_ns &&
      out_p90_ns <= out_p99_ns && out_min_ns <= out_p50_ns)
    else $error("report statistics out of order");

endmodule

bind latency_statistics_percentiles_unit lsp_checker u_lsp_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_has_samples (out_has_samples),
  .out_sample_total(out_sample_total),
  .out_min_ns      (out_min_ns),
  .out_max_ns      (out_max_ns),
  .out_p50_ns      (out_p50_ns),
  .out_p90_ns      (out_p90_ns),
  .out_p99_ns      (out_p99_ns)
);
`default_nettype wire

// File: sim/tb_latency_statistics_percentiles_unit.sv
`default_nettype none
module tb_latency_statistics_percentiles_unit;
  import lsp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WIN = WINDOW_DEPTH_DEF;
  localparam int DRAIN_CYCLES = 2 * WIN + 400;

  typedef struct {
    logic              cmd;
    logic [DATA_W-1:0] lat;
  } beat_t;

  typedef struct {
    logic              has;
    logic [DATA_W-1:0] total, mn, mx, mean, jit, p50, p90, p99;
  } report_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic              in_cmd = CMD_ADD;
  logic [DATA_W-1:0] in_latency_ns = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic              out_has_samples;
  logic [DATA_W-1:0] out_sample_total, out_min_ns, out_max_ns, out_mean_ns;
  logic [DATA_W-1:0] out_jitter_ns, out_p50_ns, out_p90_ns, out_p99_ns;

  latency_statistics_percentiles_unit dut (.*);

  // shadow statistics state
  logic [63:0]       sum_lat, sum_sq;
  logic [DATA_W-1:0] lo_lat, hi_lat, n_seen;
  int                fill, slot;
  logic [DATA_W-1:0] ring [WIN];

  beat_t   pending_beats[$];
  report_t expected_reports[$];
  int      cyc, errors, adds_taken, reports_taken, reports_checked, hold_left;
  bit      stim_done;

  initial forever #4 clk = ~clk;

  function automatic logic [63:0] isqrt128(input logic [127:0] v);
    logic [63:0] r, c;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      c = r | (64'd1 << b);
      if (128'(c) * 128'(c) <= v) r = c;
    end
    return r;
  endfunction

  function automatic logic [DATA_W-1:0] clamp32(input logic [63:0] v);
    return (v > 64'hFFFF_FFFF) ? '1 : v[DATA_W-1:0];
  endfunction

  task automatic absorb_beat(input beat_t b);
    report_t r;
    logic [127:0] a, s;
    logic [DATA_W-1:0] srt [WIN];
    logic [DATA_W-1:0] v;
    int n, j;
    if (b.cmd == CMD_ADD) begin
      adds_taken++;
      sum_lat += 64'(b.lat);
      sum_sq += 64'(b.lat) * 64'(b.lat);
      if (b.lat < lo_lat) lo_lat = b.lat;
      if (b.lat > hi_lat) hi_lat = b.lat;
      if (n_seen != '1) n_seen++;
      if (fill < WIN) fill++;
      ring[slot] = b.lat;
      slot = (slot + 1) % WIN;
      return;
    end
    reports_taken++;
    r = '{default: '0};
    if (n_seen != 0) begin
      r.has = 1'b1;
      r.total = n_seen;
      r.mn = lo_lat;
      r.mx = hi_lat;
      r.mean = clamp32(sum_lat / 64'(n_seen));
      if (n_seen >= 2) begin
        a = 128'(n_seen) * 128'(sum_sq);
        s = 128'(sum_lat) * 128'(sum_lat);
        if (a > s) r.jit = clamp32(isqrt128(a - s) / 64'(n_seen));
      end
      n = fill;
      for (int i = 0; i < n; i++) srt[i] = ring[i];
      for (int i = 1; i < n; i++) begin
        v = srt[i];
        j = i;
        while (j > 0 && srt[j-1] > v) begin
          srt[j] = srt[j-1];
          j--;
        end
        srt[j] = v;
      end
      r.p50 = srt[n * 50 / 100];
      r.p90 = srt[n * 90 / 100];
      r.p99 = srt[n * 99 / 100];
    end
    expected_reports.push_back(r);
  endtask

  function automatic void check_field(input string name, input logic [DATA_W-1:0] exp_v,
                                      input logic [DATA_W-1:0] act_v);
    if (exp_v !== act_v) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
    end
  endfunction

  // long stretch without random idling on either side
  function automatic bit idle_now();
    if (cyc >= 12000 && cyc < 18000) return 1'b0;
    return $urandom_range(0, 99) < 26;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      cyc <= 0;
    end else begin
      cyc <= cyc + 1;
    end
  end

  // driver
  always @(posedge clk) begin : drv
    beat_t b;
    if (rst_n && (!in_valid || !in_stall)) begin
      if (in_valid) absorb_beat('{cmd: in_cmd, lat: in_latency_ns});
      if (pending_beats.size() > 0 && !idle_now()) begin
        b = pending_beats.pop_front();
        in_cmd <= b.cmd;
        in_latency_ns <= b.lat;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver hold-off, counted in its own process
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
    end else if (cyc == 3000) begin
      hold_left <= 3000;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk) begin
    if (rst_n) out_stall <= (hold_left > 1) || idle_now();
  end

  // monitor
  always @(posedge clk) begin : mon
    report_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_reports.size() == 0) begin
        errors++;
        $display("%0t: unexpected report beat, expected none, got count %0d", $time,
                 out_sample_total);
      end else begin
        e = expected_reports.pop_front();
        reports_checked++;
        check_field("has_samples", 32'(e.has), 32'(out_has_samples));
        check_field("sample_total", e.total, out_sample_total);
        check_field("min_ns", e.mn, out_min_ns);
        check_field("max_ns", e.mx, out_max_ns);
        check_field("mean_ns", e.mean, out_mean_ns);
        check_field("jitter_ns", e.jit, out_jitter_ns);
        check_field("p50_ns", e.p50, out_p50_ns);
        check_field("p90_ns", e.p90, out_p90_ns);
        check_field("p99_ns", e.p99, out_p99_ns);
      end
    end
  end

  function automatic logic [DATA_W-1:0] pick_latency();
    case ($urandom_range(0, 9))
      0: return '1 - $urandom_range(0, 3);
      1: return $urandom_range(0, 3);
      2, 3: return $urandom();
      default: return $urandom_range(0, 5000);
    endcase
  endfunction

  task automatic queue_beat(input logic cmd, input logic [DATA_W-1:0] lat);
    pending_beats.push_back('{cmd: cmd, lat: lat});
  endtask

  initial begin
    sum_lat = '0;
    sum_sq = '0;
    lo_lat = '1;
    hi_lat = '0;
    n_seen = '0;
    fill = 0;
    slot = 0;
    errors = 0;
    adds_taken = 0;
    reports_taken = 0;
    reports_checked = 0;
    stim_done = 1'b0;
    // empty stats, then single sample, then huge values that wrap the square sum
    queue_beat(CMD_REPORT, '1);
    queue_beat(CMD_ADD, '0);
    queue_beat(CMD_REPORT, '0);
    queue_beat(CMD_ADD, '1);
    queue_beat(CMD_REPORT, 32'h5555_5555);
    queue_beat(CMD_ADD, '1);
    queue_beat(CMD_ADD, 32'hFFFF_FFFE);
    queue_beat(CMD_REPORT, 32'hAAAA_AAAA);
    queue_beat(CMD_ADD, 32'd1);
    queue_beat(CMD_ADD, 32'h8000_0000);
    queue_beat(CMD_ADD, 32'd7);
    queue_beat(CMD_REPORT, '0);
    for (int i = 0; i < 800; i++)
      queue_beat(($urandom_range(0, 99) < 7) ? CMD_REPORT : CMD_ADD, pick_latency());
    queue_beat(CMD_REPORT, '0);
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    wait (pending_beats.size() == 0);
    @(posedge clk iff (!in_valid || !in_stall));
    @(posedge clk);
    wait (expected_reports.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Covered %0d sample beats and %0d report beats; %0d reports checked.",
             adds_taken, reports_taken, reports_checked);
    if (errors == 0 && expected_reports.size() == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

  initial begin
    #20_000_000;
    $display("Timeout with %0d reports outstanding", expected_reports.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule
`default_nettype wire
